>>> rtl/core/dpp_pkg.sv
`timescale 1ns / 1ps

package dpp_pkg;

    // Fixed point format of every coordinate, normal and offset.
    localparam int COORD_BITS    = 32;
    localparam int FRACTION_BITS = 16;

    // Derived arithmetic widths.
    localparam int PROD_BITS = 2 * COORD_BITS;          // n_i * p_i, n_i * n_i
    localparam int SUM_BITS  = 2 * COORD_BITS + 2;      // n.p + d at full precision
    localparam int NORM_BITS = 2 * COORD_BITS;          // |n|^2, unsigned
    localparam int WL_BITS   = COORD_BITS - 1 + FRACTION_BITS;
    localparam int NUM_BITS  = 2 * COORD_BITS + 3;      // level - s
    localparam int X_BITS    = 3 * COORD_BITS + 3;      // n_i * (level - s)
    localparam int DIVN_BITS = 3 * COORD_BITS + 5;      // 2|x| + b
    localparam int DIVD_BITS = 2 * COORD_BITS + 1;      // 2b

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_OFFSET   = 3'd3,
        REG_WIDTH    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic                         inside_half_open;
        logic                         inside_closed;
        logic signed [COORD_BITS-1:0] lower_x;
        logic signed [COORD_BITS-1:0] lower_y;
        logic signed [COORD_BITS-1:0] lower_z;
        logic signed [COORD_BITS-1:0] upper_x;
        logic signed [COORD_BITS-1:0] upper_y;
        logic signed [COORD_BITS-1:0] upper_z;
        logic                         degenerate;
    } result_t;

    // Control that travels alongside each divider lane.
    typedef struct packed {
        logic valid;
        logic neg;
    } div_tag_t;

endpackage

>>> rtl/core/dpp_div.sv
`timescale 1ns / 1ps

module dpp_div #(
    parameter int QUOT_BITS = dpp_pkg::COORD_BITS,
    parameter int NUM_W     = dpp_pkg::DIVN_BITS,
    parameter int DEN_W     = dpp_pkg::DIVD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpp_pkg::div_tag_t    tag_in,
    input  logic [NUM_W-1:0]     num_in,
    input  logic [DEN_W-1:0]     den_in,
    output dpp_pkg::div_tag_t    tag_out,
    output logic [QUOT_BITS-1:0] quot,
    output logic                 ovf
);
    import dpp_pkg::*;

    // Stage 0 checks whether the quotient fits in QUOT_BITS; each later
    // stage settles one quotient bit, most significant first.
    div_tag_t               tag_reg  [QUOT_BITS+1];
    logic [NUM_W-1:0]       rem_reg  [QUOT_BITS+1];
    logic [DEN_W-1:0]       den_reg  [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   quot_reg [QUOT_BITS+1];
    logic                   ovf_reg  [QUOT_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num_in;
        den_reg[0]  <= den_in;
        quot_reg[0] <= '0;
        ovf_reg[0]  <= num_in >= (NUM_W'(den_in) << QUOT_BITS);
    end

    for (genvar s = 1; s <= QUOT_BITS; s++)
    begin : g_step
        localparam int SH = QUOT_BITS - s;
        logic [NUM_W-1:0] trial;
        logic             take;

        assign trial = NUM_W'(den_reg[s-1]) << SH;
        assign take  = rem_reg[s-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= take ? rem_reg[s-1] - trial : rem_reg[s-1];
            quot_reg[s] <= quot_reg[s-1] | (take ? (QUOT_BITS'(1) << SH) : '0);
            den_reg[s]  <= den_reg[s-1];
            ovf_reg[s]  <= ovf_reg[s-1];
        end
    end

    assign tag_out = tag_reg[QUOT_BITS];
    assign quot    = quot_reg[QUOT_BITS];
    assign ovf     = ovf_reg[QUOT_BITS];

    // A finished division leaves a remainder below the divisor.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        tag_out.valid && !ovf |-> rem_reg[QUOT_BITS] < NUM_W'(den_reg[QUOT_BITS]))
        else $error("divider remainder not below divisor");

    // Every valid result at the output had a valid entry at its range check.
    a_valid_latency: assert property (@(posedge clk) disable iff (!rst_n)
        tag_out.valid |-> $past(tag_reg[0].valid, QUOT_BITS))
        else $error("divider output valid without matching entry");

    // The overflow decision made at entry is the one delivered.
    a_ovf_carried: assert property (@(posedge clk) disable iff (!rst_n)
        tag_out.valid |-> ovf == $past(ovf_reg[0], QUOT_BITS))
        else $error("divider overflow flag changed in flight");

endmodule

>>> rtl/core/digital_plane_point_test_projection_core.sv
`timescale 1ns / 1ps
// Throughput: one point per cycle, sustained; busy is never raised.
// The quotient pipeline settles one rounded quotient bit per stage.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads
// normal = (0, 0, 1.0), offset = 0, width = 1.0; the receiver cannot stall.

module digital_plane_point_test_projection_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dpp_pkg::point_t                     point,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dpp_pkg::COORD_BITS-1:0]      cfg_data,
    output logic                                result_valid,
    output dpp_pkg::result_t                    result
);
    import dpp_pkg::*;

    // The pipeline keeps no state between points, so every stage simply
    // advances each cycle. Stages:
    //   1  the six products n_i*p_i and n_i*n_i
    //   2  s = n.p + d (exact) and b = |n|^2
    //   3  membership flags and the two numerators level - s
    //   4  partial products of n_i times each numerator (split in halves)
    //   5  partial products combined into x = n_i*(level - s)
    //   6  divider operands 2|x| + b and 2b (round half away from zero)
    //   then COORD_BITS+1 divider stages and one output stage that adds
    //   the point, saturates and forces zero for a degenerate normal.
    localparam int C         = COORD_BITS;
    localparam int LANES     = 6;
    localparam int DIV_LAT   = C + 1;
    localparam int TOTAL_LAT = 6 + DIV_LAT + 1;
    localparam int PL_BITS   = 2 * C + 1;
    localparam int PH_BITS   = 2 * C + 3;
    localparam int EXT_BITS  = C + 2;

    localparam logic signed [C-1:0] COORD_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] COORD_MIN = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [EXT_BITS-1:0] EXT_MAX = EXT_BITS'(COORD_MAX);
    localparam logic signed [EXT_BITS-1:0] EXT_MIN = EXT_BITS'(COORD_MIN);

    // Sideband that rides next to the divider lanes.
    typedef struct packed {
        logic [2:0][C-1:0] pt;
        logic              deg;
        logic              half_open;
        logic              closed;
    } side_t;

    // Every cycle may carry a new transaction.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers. The user must send writes only while the
    // pipeline is empty (the block does not enforce it); stages read them directly.
    // ------------------------------------------------------------------
    logic signed [C-1:0] normal_x_reg;
    logic signed [C-1:0] normal_y_reg;
    logic signed [C-1:0] normal_z_reg;
    logic signed [C-1:0] offset_reg;
    logic [C-2:0]        width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= '0;
            normal_y_reg <= '0;
            normal_z_reg <= C'(1) << FRACTION_BITS;
            offset_reg   <= '0;
            width_reg    <= (C-1)'(1) << FRACTION_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NORMAL_X: normal_x_reg <= $signed(cfg_data);
                REG_NORMAL_Y: normal_y_reg <= $signed(cfg_data);
                REG_NORMAL_Z: normal_z_reg <= $signed(cfg_data);
                REG_OFFSET:   offset_reg   <= $signed(cfg_data);
                REG_WIDTH:    width_reg    <= cfg_data[C-2:0];
                default:      ;
            endcase
        end
    end

    logic signed [C-1:0] nvec [3];
    assign nvec[0] = normal_x_reg;
    assign nvec[1] = normal_y_reg;
    assign nvec[2] = normal_z_reg;

    // ------------------------------------------------------------------
    // Valid bits of the front stages.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products. Each is a C by C signed multiply.
    // ------------------------------------------------------------------
    logic signed [PROD_BITS-1:0] prod_reg [3];
    logic signed [PROD_BITS-1:0] sq_reg   [3];
    logic [2:0][C-1:0]           pt1_reg;
    logic                        deg1_reg;

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= normal_x_reg * point.point_x;
        prod_reg[1] <= normal_y_reg * point.point_y;
        prod_reg[2] <= normal_z_reg * point.point_z;
        sq_reg[0]   <= normal_x_reg * normal_x_reg;
        sq_reg[1]   <= normal_y_reg * normal_y_reg;
        sq_reg[2]   <= normal_z_reg * normal_z_reg;
        pt1_reg     <= {point.point_z, point.point_y, point.point_x};
        deg1_reg    <= (normal_x_reg == '0) && (normal_y_reg == '0) && (normal_z_reg == '0);
    end

    // ------------------------------------------------------------------
    // Stage 2: exact signed distance s and squared norm b. The squares
    // are never negative, so b is summed as an unsigned value.
    // ------------------------------------------------------------------
    logic signed [SUM_BITS-1:0] s2_reg;
    logic [NORM_BITS-1:0]       b2_reg;
    logic [WL_BITS-1:0]         wl2_reg;
    logic [2:0][C-1:0]          pt2_reg;
    logic                       deg2_reg;

    always_ff @(posedge clk)
    begin
        s2_reg   <= SUM_BITS'(prod_reg[0]) + SUM_BITS'(prod_reg[1])
                  + SUM_BITS'(prod_reg[2]) + (SUM_BITS'(offset_reg) <<< FRACTION_BITS);
        b2_reg   <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1]) + $unsigned(sq_reg[2]);
        wl2_reg  <= WL_BITS'(width_reg) << FRACTION_BITS;
        pt2_reg  <= pt1_reg;
        deg2_reg <= deg1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: membership against the slab and the two numerators.
    // The width is compared at the same scale as s, with no rounding.
    // ------------------------------------------------------------------
    logic signed [SUM_BITS-1:0] wl_s;
    assign wl_s = $signed(SUM_BITS'(wl2_reg));

    logic signed [NUM_BITS-1:0] num_lo3_reg;
    logic signed [NUM_BITS-1:0] num_hi3_reg;
    logic [NORM_BITS-1:0]       b3_reg;
    side_t                      side3_reg;

    always_ff @(posedge clk)
    begin
        num_lo3_reg         <= -NUM_BITS'(s2_reg);
        num_hi3_reg         <= NUM_BITS'(wl_s) - NUM_BITS'(s2_reg);
        b3_reg              <= b2_reg;
        side3_reg.pt        <= pt2_reg;
        side3_reg.deg       <= deg2_reg;
        side3_reg.half_open <= !s2_reg[SUM_BITS-1] && (s2_reg < wl_s);
        side3_reg.closed    <= !s2_reg[SUM_BITS-1] && (s2_reg <= wl_s);
    end

    // Sideband copies for stages 4 to 6.
    logic [NORM_BITS-1:0] b4_reg, b5_reg;
    side_t                side4_reg, side5_reg, side6_reg;

    always_ff @(posedge clk)
    begin
        b4_reg    <= b3_reg;
        b5_reg    <= b4_reg;
        side4_reg <= side3_reg;
        side5_reg <= side4_reg;
        side6_reg <= side5_reg;
    end

    // ------------------------------------------------------------------
    // Stages 4 to 6 and the dividers, one lane per projected coordinate.
    // Lanes 0..2 are the lower plane x, y, z; lanes 3..5 the upper plane.
    // The rounded quotient is floor((2|x| + b) / 2b), which rounds |x|/b
    // to nearest with ties away from zero; the sign is put back later.
    // ------------------------------------------------------------------
    logic signed [PL_BITS-1:0]  pl4_reg [LANES];
    logic signed [PH_BITS-1:0]  ph4_reg [LANES];
    logic signed [X_BITS-1:0]   x5_reg  [LANES];
    logic [DIVN_BITS-1:0]       n6_reg  [LANES];
    logic [DIVD_BITS-1:0]       d6_reg;
    logic                       neg6_reg [LANES];

    div_tag_t                   dtag  [LANES];
    logic [C-1:0]               dquot [LANES];
    logic                       dovf  [LANES];

    always_ff @(posedge clk)
    begin
        d6_reg <= {b5_reg, 1'b0};
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [NUM_BITS-1:0] num_sel;
        logic                       xsign;
        logic [X_BITS-1:0]          xmag;
        div_tag_t                   tag_in;

        assign num_sel = (l / 3 == 0) ? num_lo3_reg : num_hi3_reg;

        // The wide numerator is split so that no multiply exceeds
        // roughly C by C bits.
        always_ff @(posedge clk)
        begin
            pl4_reg[l] <= nvec[l % 3] * $signed({1'b0, num_sel[C-1:0]});
            ph4_reg[l] <= nvec[l % 3] * $signed(num_sel[NUM_BITS-1:C]);
            x5_reg[l]  <= (X_BITS'(ph4_reg[l]) <<< C) + X_BITS'(pl4_reg[l]);
        end

        // For negative x, 2|x| is 2*~x + 2; that folds into one add.
        assign xsign = x5_reg[l][X_BITS-1];
        assign xmag  = $unsigned(x5_reg[l]) ^ {X_BITS{xsign}};

        always_ff @(posedge clk)
        begin
            n6_reg[l]   <= (DIVN_BITS'(xmag) << 1) + DIVN_BITS'(b5_reg)
                         + (xsign ? DIVN_BITS'(2) : '0);
            neg6_reg[l] <= xsign;
        end

        assign tag_in.valid = v6_reg;
        assign tag_in.neg   = neg6_reg[l];

        dpp_div #(
            .QUOT_BITS (C),
            .NUM_W     (DIVN_BITS),
            .DEN_W     (DIVD_BITS)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .tag_in  (tag_in),
            .num_in  (n6_reg[l]),
            .den_in  (d6_reg),
            .tag_out (dtag[l]),
            .quot    (dquot[l]),
            .ovf     (dovf[l])
        );
    end

    // Point, flags and degenerate mark wait alongside the dividers.
    side_t side_pipe_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= side6_reg;
    end

    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            side_pipe_reg[k] <= side_pipe_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Output stage. A quotient of 2^C or more saturates whatever the
    // point, so the divider only resolves C bits plus an overflow mark.
    // ------------------------------------------------------------------
    function automatic logic signed [C-1:0] sat_coord(
        input logic [C-1:0]        q,
        input logic                ovf,
        input logic                neg,
        input logic signed [C-1:0] p
    );
        logic signed [EXT_BITS-1:0] qs;
        logic signed [EXT_BITS-1:0] sum;
        logic signed [C-1:0]        res;
        qs  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum = qs + EXT_BITS'(p);
        if (ovf)
            res = neg ? COORD_MIN : COORD_MAX;
        else if (sum > EXT_MAX)
            res = COORD_MAX;
        else if (sum < EXT_MIN)
            res = COORD_MIN;
        else
            res = sum[C-1:0];
        return res;
    endfunction

    side_t               side_out;
    logic signed [C-1:0] coord [LANES];

    assign side_out = side_pipe_reg[DIV_LAT-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign coord[l] = side_out.deg ? '0
                        : sat_coord(dquot[l], dovf[l], dtag[l].neg,
                                    $signed(side_out.pt[l % 3]));
    end

    logic    result_valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= dtag[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.inside_half_open <= side_out.half_open;
        result_reg.inside_closed    <= side_out.closed;
        result_reg.lower_x          <= coord[0];
        result_reg.lower_y          <= coord[1];
        result_reg.lower_z          <= coord[2];
        result_reg.upper_x          <= coord[3];
        result_reg.upper_y          <= coord[4];
        result_reg.upper_z          <= coord[5];
        result_reg.degenerate       <= side_out.deg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The half-open slab lies inside the closed one.
    a_slab_nesting: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.inside_half_open |-> result.inside_closed)
        else $error("half-open membership without closed membership");

    // A zero normal gives all-zero projections.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |->
            result.lower_x == '0 && result.lower_y == '0 && result.lower_z == '0 &&
            result.upper_x == '0 && result.upper_y == '0 && result.upper_z == '0)
        else $error("degenerate result with nonzero projection");

    // Each result stems from a transaction accepted a fixed time earlier.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, TOTAL_LAT))
        else $error("result strobe without matching accepted point");

endmodule
